>>> src/edt_pkg.sv
`timescale 1ns / 1ps

package edt_pkg;

    // operation codes
    localparam logic [1:0] OP_RELEASE  = 2'd0;
    localparam logic [1:0] OP_COMPLETE = 2'd1;
    localparam logic [1:0] OP_STATUS   = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_HEAD    = 3'd0;
    localparam logic [2:0] KIND_OVERDUE = 3'd1;
    localparam logic [2:0] KIND_DONE    = 3'd2;
    localparam logic [2:0] KIND_IDLE    = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;
    localparam logic [2:0] KIND_STATUS  = 3'd5;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] deadline;
        logic [31:0] exec;
    } task_entry_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic shift_left;
    } cell_ctl_t;

endpackage

>>> src/edt_cell.sv
`timescale 1ns / 1ps

module edt_cell
(
    input  logic                clk,
    input  edt_pkg::cell_ctl_t  ctl,
    input  logic                occupied,
    input  edt_pkg::task_entry_t new_entry,
    input  edt_pkg::task_entry_t prev_entry,
    input  logic                prev_gt,
    input  edt_pkg::task_entry_t next_entry,
    output edt_pkg::task_entry_t entry,
    output logic                gt
);

    edt_pkg::task_entry_t entry_reg;
    edt_pkg::task_entry_t entry_next;

    // this entry sorts after the new task (stable: equal deadlines stay ahead)
    assign gt = occupied && (entry_reg.deadline > new_entry.deadline);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift_left)
        begin
            entry_next = next_entry;
        end
        else if (ctl.insert)
        begin
            if (prev_gt)
            begin
                entry_next = prev_entry;
            end
            else if (gt || !occupied)
            begin
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> src/edf_deadline_task_queue_top.sv
`timescale 1ns / 1ps

// Earliest-deadline-first task queue. Up to TABLE_DEPTH released tasks sit in
// a row of cells, sorted by absolute deadline; a new task lands behind any
// task with an equal deadline. A release beat inserts the task in the cycle
// it is accepted (every cell compares its deadline with the new one and the
// tail shifts right by one), then the head is tested once per cycle when the
// output is free, against exec_time + now (32-bit wrap), and each overdue head
// is dropped and reported with the whole row shifting left. A complete beat
// retires the head. Every release or complete ends with a head result, or idle
// when the table is empty; full-table release, empty-table complete and unknown
// codes give one error result, and a status query gives the counters. Results
// leave through a single output register; last marks the final result of an
// input beat. With a free output, release inserts, then gives one overdue
// result per dropped head, then the head result; complete gives a done result
// and a head result; status and error give one result. At most one result is
// produced per cycle. A new input beat is taken once the final result of the
// previous one sits in the output register, even while it waits to be taken.

module edf_deadline_task_queue_top
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [15:0] task_id,
    input  logic [31:0] deadline,
    input  logic [31:0] exec_time,
    input  logic [31:0] now,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [15:0] task_out,
    output logic [31:0] time_out,
    output logic [4:0]  active_count,
    output logic [15:0] completed_count,
    output logic [15:0] overdue_count,
    output logic        last
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DONE_OUT,
        ST_HEAD,
        ST_ERR,
        ST_STATUS
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [15:0]   done_reg, done_next;
    logic [15:0]   late_reg, late_next;
    logic [31:0]   now_reg, now_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic [2:0]    kind_reg, kind_next;
    logic [15:0]   task_reg, task_next;
    logic [31:0]   time_reg, time_next;
    logic [4:0]    active_reg, active_next;
    logic [15:0]   comp_reg, comp_next;
    logic [15:0]   over_reg, over_next;
    logic          last_reg, last_next;

    edt_pkg::cell_ctl_t   ctl;
    edt_pkg::task_entry_t new_entry;
    edt_pkg::task_entry_t entries [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] occ;
    logic [TABLE_DEPTH-1:0] gt;

    logic slot_free;
    logic head_late;

    assign new_entry.id       = task_id;
    assign new_entry.deadline = deadline;
    assign new_entry.exec     = exec_time;

    // the row of cells; cell 0 is the head
    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            edt_pkg::task_entry_t prev_e;
            edt_pkg::task_entry_t next_e;
            logic                 prev_g;

            assign occ[g] = (count_reg > CW'(g));

            if (g == 0)
            begin : g_first
                assign prev_e = new_entry;
                assign prev_g = 1'b0;
            end
            else
            begin : g_mid
                assign prev_e = entries[g-1];
                assign prev_g = gt[g-1];
            end

            if (g == TABLE_DEPTH - 1)
            begin : g_tail
                assign next_e = new_entry;
            end
            else
            begin : g_body
                assign next_e = entries[g+1];
            end

            edt_cell u_cell
            (
                .clk        (clk),
                .ctl        (ctl),
                .occupied   (occ[g]),
                .new_entry  (new_entry),
                .prev_entry (prev_e),
                .prev_gt    (prev_g),
                .next_entry (next_e),
                .entry      (entries[g]),
                .gt         (gt[g])
            );
        end
    endgenerate

    // output register can take a new result this cycle
    assign slot_free = !out_valid_reg || out_ready;

    // head misses its deadline at the tick of the current beat
    assign head_late = (count_reg != '0) &&
                       (entries[0].deadline < (entries[0].exec + now_reg));

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        done_next      = done_reg;
        late_next      = late_reg;
        now_next       = now_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        task_next      = task_reg;
        time_next      = time_reg;
        active_next    = active_reg;
        comp_next      = comp_reg;
        over_next      = over_reg;
        last_next      = last_reg;
        ctl            = '0;

        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    now_next = now;
                    unique case (operation)
                        edt_pkg::OP_RELEASE:
                        begin
                            if (count_reg == CW'(TABLE_DEPTH))
                            begin
                                state_next = ST_ERR;
                            end
                            else
                            begin
                                ctl.insert = 1'b1;
                                count_next = count_reg + 1'b1;
                                state_next = ST_CHECK;
                            end
                        end
                        edt_pkg::OP_COMPLETE:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = ST_ERR;
                            end
                            else
                            begin
                                state_next = ST_DONE_OUT;
                            end
                        end
                        edt_pkg::OP_STATUS:
                        begin
                            state_next = ST_STATUS;
                        end
                        default:
                        begin
                            state_next = ST_ERR;
                        end
                    endcase
                end
            end

            ST_CHECK, ST_HEAD:
            begin
                if (slot_free)
                begin
                    if (state_reg == ST_CHECK && head_late)
                    begin
                        // drop overdue head and report it
                        ctl.shift_left = 1'b1;
                        count_next     = count_reg - 1'b1;
                        late_next      = (late_reg == edt_pkg::CNT_MAX) ? late_reg
                                                                        : late_reg + 1'b1;
                        kind_next      = edt_pkg::KIND_OVERDUE;
                        task_next      = entries[0].id;
                        time_next      = now_reg;
                        last_next      = 1'b0;
                    end
                    else
                    begin
                        if (count_reg != '0)
                        begin
                            kind_next = edt_pkg::KIND_HEAD;
                            task_next = entries[0].id;
                            time_next = entries[0].deadline;
                        end
                        else
                        begin
                            kind_next = edt_pkg::KIND_IDLE;
                            task_next = '0;
                            time_next = '0;
                        end
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    out_valid_next = 1'b1;
                    active_next    = 5'(count_next);
                    comp_next      = done_next;
                    over_next      = late_next;
                end
            end

            ST_DONE_OUT:
            begin
                if (slot_free)
                begin
                    ctl.shift_left = 1'b1;
                    count_next     = count_reg - 1'b1;
                    done_next      = (done_reg == edt_pkg::CNT_MAX) ? done_reg
                                                                    : done_reg + 1'b1;
                    out_valid_next = 1'b1;
                    kind_next      = edt_pkg::KIND_DONE;
                    task_next      = entries[0].id;
                    time_next      = now_reg;
                    active_next    = 5'(count_next);
                    comp_next      = done_next;
                    over_next      = late_next;
                    last_next      = 1'b0;
                    state_next     = ST_HEAD;
                end
            end

            ST_ERR, ST_STATUS:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = (state_reg == ST_ERR) ? edt_pkg::KIND_ERROR
                                                           : edt_pkg::KIND_STATUS;
                    task_next      = '0;
                    time_next      = '0;
                    active_next    = 5'(count_reg);
                    comp_next      = done_reg;
                    over_next      = late_reg;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            done_reg      <= '0;
            late_reg      <= '0;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= '0;
            task_reg      <= '0;
            time_reg      <= '0;
            active_reg    <= '0;
            comp_reg      <= '0;
            over_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            late_reg      <= late_next;
            now_reg       <= now_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            task_reg      <= task_next;
            time_reg      <= time_next;
            active_reg    <= active_next;
            comp_reg      <= comp_next;
            over_reg      <= over_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign task_out        = task_reg;
    assign time_out        = time_reg;
    assign active_count    = active_reg;
    assign completed_count = comp_reg;
    assign overdue_count   = over_reg;
    assign last            = last_reg;

endmodule
